// File: rtl/core/tei_pkg.sv
// tei_pkg: shared types and constants of the tree ensemble inference block
// no dependencies

package tei_pkg;

    localparam int NODE_DEPTH       = 4096;
    localparam int LEAF_VALUE_DEPTH = 8192;
    localparam int MAX_FEATURES     = 64;
    localparam int MAX_TARGETS      = 16;
    localparam int MAX_TREE_DEPTH   = 32;

    typedef enum logic [1:0] {
        OP_NODE    = 2'd0,
        OP_LEAF    = 2'd1,
        OP_FEATURE = 2'd2,
        OP_PREDICT = 2'd3
    } op_t;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_TREES  = 2'd1;
    localparam logic [1:0] CFG_TARGET = 2'd2;

    localparam logic signed [6:0]  ATTR_LEAF  = -7'sd4;
    localparam logic signed [12:0] CHILD_NONE = -13'sd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ROOT,
        ST_NODE_RD,
        ST_FEAT_RD,
        ST_NODE_EV,
        ST_LEAF_RD,
        ST_LEAF_EV,
        ST_VOTE,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear_votes;
        logic start_tree;
        logic node_read;
        logic feat_read;
        logic node_step;
        logic leaf_start;
        logic leaf_read;
        logic leaf_eval;
        logic leaf_next;
        logic vote;
        logic div_start;
        logic emit_load;
        logic emit_next;
    } cmd_t;

    typedef struct packed {
        logic is_leaf;
        logic last_tree;
        logic leaf_done;
        logic div_done;
        logic emit_last;
        logic mode;
    } sts_t;

endpackage

// File: rtl/core/tree_ensemble_inference.sv
// Tree ensemble inference: items load a node table, a leaf value table and a feature
// vector; a predict item walks every tree from its root and returns one vote count per
// class, or one regression mean. A node visit steps through node read, feature read and
// compare, a leaf value through read and compare, and each tree adds root set-up and
// vote; regression ends with a divide, and results are emitted while the output is not
// stalled. Write items are accepted whenever no predict runs. No item is accepted until
// the last result of a predict has entered the output register. Stores are undefined
// until written.

module tree_ensemble_inference
    import tei_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic [12:0]        index,
    input  logic signed [31:0] value,
    input  logic signed [6:0]  node_attribute,
    input  logic signed [12:0] node_child_start,
    input  logic [1:0]         node_child_count,
    input  logic [12:0]        node_value_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         target_index,
    output logic signed [31:0] score,
    output logic               last
);

    logic       mode_reg;
    logic [8:0] trees_reg;
    logic [4:0] target_reg;
    logic       busy;
    logic       out_free;
    logic       in_acc;
    cmd_t       cmd;
    sts_t       sts;

    assign cfg_ready = 1'b1;
    assign in_ready = !busy;
    assign in_acc = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            trees_reg <= 9'd1;
            target_reg <= 5'd2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:   mode_reg <= cfg_data[0];
                CFG_TREES:  trees_reg <= cfg_data[8:0];
                CFG_TARGET: target_reg <= cfg_data[4:0];
                default:    ;
            endcase
        end
    end

    tei_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_acc && op_t'(operation) == OP_PREDICT),
        .sts      (sts),
        .out_free (out_free),
        .busy     (busy),
        .cmd      (cmd)
    );

    tei_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (in_acc),
        .wr_op          (op_t'(operation)),
        .wr_index       (index),
        .wr_value       (value),
        .wr_attr        (node_attribute),
        .wr_child_start (node_child_start),
        .wr_child_count (node_child_count),
        .wr_value_start (node_value_start),
        .mode           (mode_reg),
        .tree_count     (trees_reg),
        .target_count   (target_reg),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .out_free       (out_free),
        .target_index   (target_index),
        .score          (score),
        .last           (last)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("item accepted during predict");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(score)
                                       && $stable(target_index) && $stable(last)))
        else $error("result changed while waiting");

endmodule

// File: rtl/core/tei_ctrl.sv
// tei_ctrl: sequencer of the tree walk, leaf scan, division and emission
// depends on tei_pkg

module tei_ctrl
    import tei_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  sts_t   sts,
    input  logic   out_free,
    output logic   busy,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                cmd.clear_votes = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sts.last_tree)
                    state_next = sts.mode ? ST_DIV : ST_EMIT;
                else
                begin
                    cmd.start_tree = 1'b1;
                    state_next = ST_NODE_RD;
                end
                if (sts.last_tree)
                begin
                    cmd.div_start = sts.mode;
                    cmd.emit_load = ~sts.mode;
                end
            end
            ST_NODE_RD:
            begin
                cmd.node_read = 1'b1;
                state_next = ST_FEAT_RD;
            end
            ST_FEAT_RD:
            begin
                cmd.feat_read = 1'b1;
                state_next = ST_NODE_EV;
            end
            ST_NODE_EV:
            begin
                if (sts.is_leaf)
                begin
                    cmd.leaf_start = 1'b1;
                    state_next = ST_LEAF_RD;
                end
                else
                begin
                    cmd.node_step = 1'b1;
                    state_next = ST_NODE_RD;
                end
            end
            ST_LEAF_RD:
            begin
                cmd.leaf_read = 1'b1;
                state_next = ST_LEAF_EV;
            end
            ST_LEAF_EV:
            begin
                cmd.leaf_eval = 1'b1;
                if (sts.leaf_done)
                    state_next = ST_VOTE;
                else
                begin
                    cmd.leaf_next = 1'b1;
                    state_next = ST_LEAF_RD;
                end
            end
            ST_VOTE:
            begin
                cmd.vote = 1'b1;
                state_next = ST_ROOT;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.emit_load = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit_next = 1'b1;
                    if (sts.emit_last)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/core/tei_div.sv
// tei_div: restoring divider, one quotient bit per cycle, signed dividend
// depends on tei_pkg

module tei_div
    import tei_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [47:0] dividend,
    input  logic [8:0]         divisor,
    output logic               done,
    output logic signed [31:0] quotient
);

    logic [47:0] quo_reg, quo_next;
    logic [9:0]  rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        run_reg, run_next;
    logic [9:0]  trial;
    logic [10:0] diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= 1'b0;
        else
            run_reg <= run_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        run_next = run_reg;
        trial = {rem_reg[8:0], quo_reg[47]};
        diff = {1'b0, trial} - {2'b00, divisor};
        if (start)
        begin
            neg_next = dividend[47];
            quo_next = dividend[47] ? 48'(-dividend) : 48'(dividend);
            rem_next = '0;
            cnt_next = 6'd48;
            run_next = (divisor != '0);
            if (divisor == '0)
            begin
                quo_next = '0;
                cnt_next = '0;
            end
        end
        else if (run_reg)
        begin
            if (!diff[10])
            begin
                rem_next = diff[9:0];
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                run_next = 1'b0;
        end
    end

    assign done = !run_reg;
    assign quotient = neg_reg ? 32'(-quo_reg[31:0]) : quo_reg[31:0];

endmodule

// File: rtl/core/tei_dp.sv
// tei_dp: node, leaf value and feature stores, walk registers, votes and output register
// depends on tei_pkg and tei_div

module tei_dp
    import tei_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  op_t                wr_op,
    input  logic [12:0]        wr_index,
    input  logic signed [31:0] wr_value,
    input  logic signed [6:0]  wr_attr,
    input  logic signed [12:0] wr_child_start,
    input  logic [1:0]         wr_child_count,
    input  logic [12:0]        wr_value_start,
    input  logic               mode,
    input  logic [8:0]         tree_count,
    input  logic [4:0]         target_count,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               out_free,
    output logic [3:0]         target_index,
    output logic signed [31:0] score,
    output logic               last
);

    localparam int NAW = $clog2(NODE_DEPTH);
    localparam int LAW = $clog2(LEAF_VALUE_DEPTH);
    localparam int FAW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int TAW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int DCW = $clog2(MAX_TREE_DEPTH + 1);
    localparam int NT_LIM = (MAX_TARGETS < 16) ? MAX_TARGETS : 16;

    logic signed [31:0] split_mem [NODE_DEPTH];
    logic [34:0]        link_mem  [NODE_DEPTH];
    logic signed [31:0] leaf_mem  [LEAF_VALUE_DEPTH];
    logic signed [31:0] feat_mem  [MAX_FEATURES];
    logic [8:0]         votes_reg [MAX_TARGETS];

    logic signed [31:0] split_rd_reg;
    logic [34:0]        link_rd_reg;
    logic               node_ok_reg;
    logic signed [31:0] feat_rd_reg;
    logic               feat_ok_reg;
    logic signed [31:0] leaf_rd_reg;
    logic               leaf_ok_reg;

    logic [13:0]        addr_reg;
    logic [8:0]         tree_reg;
    logic [DCW-1:0]     depth_reg;
    logic [12:0]        vstart_reg;
    logic [4:0]         k_reg;
    logic signed [31:0] best_reg;
    logic [4:0]         cls_reg;
    logic signed [47:0] sum_reg;
    logic [4:0]         nt;

    logic               oval_reg;
    logic [3:0]         otgt_reg;
    logic signed [31:0] oscore_reg;
    logic               olast_reg;
    logic [4:0]         ek_reg;

    logic signed [6:0]  n_attr;
    logic signed [12:0] n_cs;
    logic [1:0]         n_cc;
    logic [12:0]        n_vs;
    logic signed [31:0] n_split;
    logic signed [31:0] feat_v;
    logic signed [31:0] leaf_v;
    logic [13:0]        leaf_addr;
    logic               div_done;
    logic signed [31:0] quotient;

    always_comb
    begin
        nt = target_count;
        if (nt == 5'd0)
            nt = 5'd1;
        if (nt > 5'(NT_LIM))
            nt = 5'(NT_LIM);
    end

    // writes
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_op == OP_NODE && 32'(wr_index) < NODE_DEPTH)
        begin
            split_mem[wr_index[NAW-1:0]] <= wr_value;
            link_mem[wr_index[NAW-1:0]] <= {wr_attr, wr_child_start, wr_child_count,
                                            wr_value_start};
        end
        if (wr_en && wr_op == OP_LEAF && 32'(wr_index) < LEAF_VALUE_DEPTH)
            leaf_mem[wr_index[LAW-1:0]] <= wr_value;
        if (wr_en && wr_op == OP_FEATURE && 32'(wr_index) < MAX_FEATURES)
            feat_mem[wr_index[FAW-1:0]] <= wr_value;
    end

    // node and leaf value reads
    always_ff @(posedge clk)
    begin
        if (cmd.node_read)
        begin
            split_rd_reg <= split_mem[addr_reg[NAW-1:0]];
            link_rd_reg <= link_mem[addr_reg[NAW-1:0]];
            node_ok_reg <= !addr_reg[13] && 32'(addr_reg) < NODE_DEPTH;
        end
        if (cmd.leaf_read)
        begin
            leaf_rd_reg <= leaf_mem[leaf_addr[LAW-1:0]];
            leaf_ok_reg <= 32'(leaf_addr) < LEAF_VALUE_DEPTH;
        end
    end

    assign n_attr  = node_ok_reg ? link_rd_reg[34:28] : '0;
    assign n_cs    = node_ok_reg ? link_rd_reg[27:15] : '0;
    assign n_cc    = node_ok_reg ? link_rd_reg[14:13] : '0;
    assign n_vs    = node_ok_reg ? link_rd_reg[12:0]  : '0;
    assign n_split = node_ok_reg ? split_rd_reg : '0;
    assign leaf_v  = leaf_ok_reg ? leaf_rd_reg : '0;
    assign leaf_addr = {1'b0, vstart_reg} + 14'(k_reg);

    // feature read registered from the node read data, in the cycle after the node read
    always_ff @(posedge clk)
    begin
        if (cmd.feat_read)
        begin
            feat_ok_reg <= !n_attr[6] && 32'(n_attr) < MAX_FEATURES;
            feat_rd_reg <= feat_mem[n_attr[FAW-1:0]];
        end
    end
    assign feat_v = feat_ok_reg ? feat_rd_reg : '0;

    assign sts.is_leaf = (n_cc == 2'd0) || (n_cs == CHILD_NONE) || (n_attr == ATTR_LEAF)
                         || (32'(depth_reg) >= MAX_TREE_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_reg <= '0;
            for (int i = 0; i < MAX_TARGETS; i++)
                votes_reg[i] <= '0;
        end
        else
        begin
            if (cmd.clear_votes)
            begin
                tree_reg <= '0;
                for (int i = 0; i < MAX_TARGETS; i++)
                    votes_reg[i] <= '0;
            end
            if (cmd.vote)
            begin
                tree_reg <= tree_reg + 9'd1;
                if (!mode)
                    votes_reg[cls_reg[TAW-1:0]] <= votes_reg[cls_reg[TAW-1:0]] + 9'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_votes)
            sum_reg <= '0;
        if (cmd.start_tree)
        begin
            addr_reg <= {5'd0, tree_reg};
            depth_reg <= '0;
        end
        if (cmd.node_step)
        begin
            addr_reg <= (feat_v < n_split) ? {n_cs[12], n_cs} : 14'({n_cs[12], n_cs} + 14'd1);
            depth_reg <= depth_reg + DCW'(1);
        end
        if (cmd.leaf_start)
        begin
            vstart_reg <= n_vs;
            k_reg <= '0;
            best_reg <= '0;
            cls_reg <= '0;
        end
        if (cmd.leaf_eval)
        begin
            if (mode)
                sum_reg <= sum_reg + 48'(leaf_v);
            else if (best_reg < leaf_v)
            begin
                best_reg <= leaf_v;
                cls_reg <= k_reg;
            end
        end
        if (cmd.leaf_next)
            k_reg <= k_reg + 5'd1;
    end

    assign sts.leaf_done = mode || (k_reg + 5'd1 >= nt);
    assign sts.last_tree = (tree_reg >= tree_count);
    assign sts.mode = mode;
    assign sts.div_done = div_done;
    assign sts.emit_last = (ek_reg + 5'd1 >= nt) || mode;

    tei_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (tree_count),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_free = !oval_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oval_reg <= 1'b0;
            ek_reg <= '0;
        end
        else
        begin
            if (out_ready)
                oval_reg <= 1'b0;
            if (cmd.emit_load)
                ek_reg <= '0;
            if (cmd.emit_next)
            begin
                oval_reg <= 1'b1;
                ek_reg <= ek_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_next)
        begin
            otgt_reg <= mode ? 4'd0 : ek_reg[3:0];
            oscore_reg <= mode ? quotient : 32'(votes_reg[ek_reg[TAW-1:0]]);
            olast_reg <= sts.emit_last;
        end
    end

    assign out_valid = oval_reg;
    assign target_index = otgt_reg;
    assign score = oscore_reg;
    assign last = olast_reg;

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for the tree ensemble inference block
// loads node, leaf value and feature tables, runs predicts under several register settings
// depends on tei_pkg and tree_ensemble_inference
`timescale 1ns / 1ps

module tb_top;
    import tei_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int NODES = 4096;
    localparam int LEAVES = 8192;
    localparam int FEATS = 64;
    localparam int TARGETS = 16;
    localparam int DEPTH_LIMIT = 32;
    localparam int STALL_LIMIT = 40000;

    typedef struct {
        op_t               op;
        logic [12:0]       idx;
        logic signed [31:0] val;
        logic signed [6:0]  attr;
        logic signed [12:0] cstart;
        logic [1:0]        ccount;
        logic [12:0]       vstart;
    } item_t;

    typedef struct {
        logic [3:0]  tgt;
        logic [31:0] score;
        logic        last;
    } score_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = CFG_MODE;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    op_t operation = OP_NODE;
    logic [12:0] index = '0;
    logic signed [31:0] value = '0;
    logic signed [6:0] node_attribute = '0;
    logic signed [12:0] node_child_start = '0;
    logic [1:0] node_child_count = '0;
    logic [12:0] node_value_start = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [3:0] target_index;
    logic signed [31:0] score;
    logic last;

    tree_ensemble_inference u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation), .index(index),
        .value(value), .node_attribute(node_attribute), .node_child_start(node_child_start),
        .node_child_count(node_child_count), .node_value_start(node_value_start),
        .out_valid(out_valid), .out_ready(out_ready), .target_index(target_index),
        .score(score), .last(last)
    );

    always #5 clk = ~clk;

    // shadow state
    logic signed [31:0] split_mem [NODES];
    logic signed [6:0]  attr_mem [NODES];
    logic signed [12:0] child_mem [NODES];
    logic [1:0]         count_mem [NODES];
    logic [12:0]        vstart_mem [NODES];
    logic signed [31:0] leaf_mem [LEAVES];
    logic signed [31:0] feat_mem [FEATS];
    logic       reg_mode = 1'b0;
    logic [8:0] reg_trees = 9'd1;
    logic [4:0] reg_targets = 5'd2;

    item_t  pending_items[$];
    score_t expected_scores[$];
    item_t  cur;
    logic in_fire = 1'b0;
    int send_pct = 0;
    int recv_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int errors = 0;

    function automatic int unsigned walk_tree(int root);
        int addr;
        int feat;
        addr = root;
        for (int steps = 0; ; steps++)
        begin
            if (addr < 0 || addr >= NODES)
                return 0;
            if (count_mem[addr] == 0 || child_mem[addr] == CHILD_NONE
                || attr_mem[addr] == ATTR_LEAF)
                return 32'(vstart_mem[addr]);
            if (steps >= DEPTH_LIMIT)
                return 32'(vstart_mem[addr]);
            feat = (attr_mem[addr] < 0 || attr_mem[addr] >= FEATS) ? 0 : feat_mem[attr_mem[addr]];
            if (feat < int'(split_mem[addr]))
                addr = int'(child_mem[addr]);
            else
                addr = int'(child_mem[addr]) + 1;
        end
    endfunction

    function automatic int leaf_at(int addr);
        return (addr < 0 || addr >= LEAVES) ? 0 : leaf_mem[addr];
    endfunction

    task automatic add_expected(score_t s);
        expected_scores = {expected_scores, s};
    endtask

    task automatic queue_item(item_t it);
        pending_items = {pending_items, it};
    endtask

    task automatic apply_item(item_t it);
        int unsigned vs;
        int nt;
        int best;
        int cls;
        int votes [TARGETS];
        longint sum;
        longint mean;
        score_t s;
        case (it.op)
            OP_NODE:
            begin
                if (it.idx < NODES)
                begin
                    split_mem[it.idx] = it.val;
                    attr_mem[it.idx] = it.attr;
                    child_mem[it.idx] = it.cstart;
                    count_mem[it.idx] = it.ccount;
                    vstart_mem[it.idx] = it.vstart;
                end
            end
            OP_LEAF:
                leaf_mem[it.idx] = it.val;
            OP_FEATURE:
            begin
                if (it.idx < FEATS)
                    feat_mem[it.idx] = it.val;
            end
            default:
            begin
                if (reg_mode)
                begin
                    sum = 0;
                    mean = 0;
                    for (int t = 0; t < reg_trees; t++)
                        sum += leaf_at(walk_tree(t));
                    if (reg_trees != 0)
                        mean = sum / longint'(reg_trees);
                    s.tgt = '0;
                    s.score = mean[31:0];
                    s.last = 1'b1;
                    add_expected(s);
                end
                else
                begin
                    nt = int'(reg_targets);
                    if (nt < 1) nt = 1;
                    if (nt > TARGETS) nt = TARGETS;
                    for (int k = 0; k < TARGETS; k++)
                        votes[k] = 0;
                    for (int t = 0; t < reg_trees; t++)
                    begin
                        vs = walk_tree(t);
                        best = 0;
                        cls = 0;
                        for (int k = 0; k < nt; k++)
                        begin
                            if (best < leaf_at(vs + k))
                            begin
                                best = leaf_at(vs + k);
                                cls = k;
                            end
                        end
                        votes[cls]++;
                    end
                    for (int k = 0; k < nt; k++)
                    begin
                        s.tgt = k[3:0];
                        s.score = votes[k];
                        s.last = (k + 1 == nt);
                        add_expected(s);
                    end
                end
            end
        endcase
    endtask

    // inputs: acceptance, prediction and result checks at the rising edge
    always @(posedge clk)
    begin
        score_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_scores.size() == 0)
                begin
                    $display("%0t unexpected result: target %0d score %0d last %0d",
                             $time, target_index, score, last);
                    errors++;
                end
                else
                begin
                    e = expected_scores.pop_front();
                    if (e.tgt !== target_index || e.score !== score || e.last !== last)
                    begin
                        $display("%0t mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 $time, e.tgt, $signed(e.score), e.last,
                                 target_index, score, last);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                apply_item(cur);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t no progress", $time);
                $display("status: fail");
                $finish;
            end
        end
        in_fire <= in_valid && in_ready;
    end

    // item driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_pct)
            begin
                cur = pending_items.pop_front();
                operation <= cur.op;
                index <= cur.idx;
                value <= cur.val;
                node_attribute <= cur.attr;
                node_child_start <= cur.cstart;
                node_child_count <= cur.ccount;
                node_value_start <= cur.vstart;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_seen != hold_seq)
        begin
            hold_seen <= hold_seq;
            hold_left <= 300;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(99) >= recv_pct);
    end

    function automatic item_t node_item(int idx);
        item_t it;
        int r;
        it.op = OP_NODE;
        it.idx = idx[12:0];
        it.val = $urandom;
        r = $urandom_range(9);
        if (r == 0) it.cstart = CHILD_NONE;
        else if (r == 1) it.cstart = -13'($urandom_range(4096, 2));
        else if (r == 2) it.cstart = 13'sd4095;
        else it.cstart = 13'($urandom_range(30));
        r = $urandom_range(9);
        if (r == 0) it.attr = ATTR_LEAF;
        else if (r == 1) it.attr = 7'($urandom);
        else it.attr = 7'($urandom_range(63));
        it.ccount = 2'($urandom);
        it.vstart = ($urandom_range(4) == 0) ? 13'($urandom_range(8191, 8184))
                                             : 13'($urandom_range(16));
        return it;
    endfunction

    function automatic item_t plain_item(op_t op, int idx, logic [31:0] v);
        item_t it;
        it = node_item(0);
        it.op = op;
        it.idx = idx[12:0];
        it.val = v;
        return it;
    endfunction

    function automatic item_t random_item();
        int r;
        int a;
        r = $urandom_range(99);
        if (r < 30)
        begin
            r = $urandom_range(19);
            if (r == 0) a = 4095;
            else if (r == 1) a = $urandom_range(8191, 4096);
            else a = $urandom_range(31);
            return node_item(a);
        end
        if (r < 50)
        begin
            r = $urandom_range(9);
            if (r == 0) a = $urandom_range(8191);
            else if (r == 1) a = $urandom_range(8191, 8176);
            else a = $urandom_range(127);
            return plain_item(OP_LEAF, a, $urandom);
        end
        if (r < 70)
        begin
            a = ($urandom_range(9) == 0) ? $urandom_range(8191, 64) : $urandom_range(63);
            return plain_item(OP_FEATURE, a, $urandom);
        end
        return plain_item(OP_PREDICT, $urandom_range(8191), $urandom);
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_MODE) reg_mode = data[0];
        else if (idx == CFG_TREES) reg_trees = data[8:0];
        else if (idx == CFG_TARGET) reg_targets = data[4:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_scores.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic run_phase(int m, int trees, int targets, int sp, int rp, int n);
        drain();
        send_pct = sp;
        recv_pct = rp;
        cfg_write(CFG_MODE, ($urandom << 1) | 32'(m));
        cfg_write(CFG_TREES, ($urandom << 9) | 32'(trees));
        cfg_write(CFG_TARGET, ($urandom << 5) | 32'(targets));
        cfg_write(CFG_UNUSED, $urandom);
        for (int i = 0; i < n; i++)
            queue_item(random_item());
        queue_item(plain_item(OP_PREDICT, 0, 0));
    endtask

    initial
    begin
        item_t it;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        // table load
        for (int i = 0; i < 32; i++)
            queue_item(node_item(i));
        queue_item(node_item(4095));
        for (int i = 0; i < 32; i++)
            queue_item(plain_item(OP_LEAF, i, $urandom));
        for (int i = 8184; i < 8192; i++)
            queue_item(plain_item(OP_LEAF, i, $urandom));
        for (int i = 0; i < FEATS; i++)
            queue_item(plain_item(OP_FEATURE, i, $urandom));
        // directed corners, reset register values
        queue_item(plain_item(OP_PREDICT, 0, 0));
        queue_item(plain_item(OP_FEATURE, 0, 32'h8000_0000));
        queue_item(plain_item(OP_FEATURE, 63, 32'h7fff_ffff));
        queue_item(plain_item(OP_FEATURE, 8191, 32'hffff_ffff));
        queue_item(plain_item(OP_LEAF, 8191, 32'h7fff_ffff));
        queue_item(plain_item(OP_LEAF, 0, 32'h8000_0000));
        it = node_item(0);
        it.attr = ATTR_LEAF;
        queue_item(it);
        queue_item(plain_item(OP_PREDICT, 0, 0));
        it = node_item(0);
        it.attr = 7'sd0; it.cstart = CHILD_NONE; it.ccount = 2'd2;
        queue_item(it);
        queue_item(plain_item(OP_PREDICT, 0, 0));
        it = node_item(0);
        it.attr = 7'sd63; it.cstart = -13'sd4096; it.ccount = 2'd1; it.val = 32'h8000_0000;
        queue_item(it);
        queue_item(plain_item(OP_PREDICT, 0, 0));
        it = node_item(0);
        it.attr = -7'sd64; it.cstart = 13'sd4095; it.ccount = 2'd3; it.val = 32'h7fff_ffff;
        queue_item(it);
        queue_item(node_item(8191));
        it = node_item(1);
        it.attr = 7'sd0; it.cstart = 13'sd0; it.ccount = 2'd2; it.val = 32'h8000_0000;
        queue_item(it);
        queue_item(plain_item(OP_PREDICT, 8191, 32'hffff_ffff));
        // settings sweep
        run_phase(0, 3, 4, 0, 0, 6);
        run_phase(1, 5, 2, 45, 0, 5);
        run_phase(0, 1, 16, 0, 45, 5);
        run_phase(1, 0, 1, 16, 16, 3);
        run_phase(0, 0, 0, 0, 0, 3);
        run_phase(0, 8, 31, 16, 16, 5);
        run_phase(1, 32, 3, 0, 0, 2);
        run_phase(0, 32, 16, 45, 45, 2);
        run_phase(1, 2, 7, 0, 0, 4);
        run_phase(0, 6, 5, 0, 0, 0);
        hold_seq++;
        for (int i = 0; i < 10; i++)
            queue_item(plain_item(OP_PREDICT, i, $urandom));
        run_phase(0, 4, 3, 45, 45, 6);
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
